// ===== hw/rtl/slru_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types for the segmented lru replacement block
// no dependencies
package slru_pkg;

    // default segment depth and block number width
    localparam int SEG_DEPTH_DEF = 8;
    localparam int ID_BITS_DEF   = 32;

    // fixed port widths
    localparam int ID_PORT_W = 32;
    localparam int CAP_W     = 4;
    localparam int CFG_IDX_W = 1;

    // reset value of both capacity registers
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT_CAP = 1'b1;

    // access outcome codes
    localparam logic [1:0] OUT_MISS      = 2'd0;
    localparam logic [1:0] OUT_PROB_HIT  = 2'd1;
    localparam logic [1:0] OUT_PROT_HIT  = 2'd2;
    localparam logic [1:0] OUT_PROT_HEAD = 2'd3;

    // per-cell control from the segment to one cell
    typedef struct packed {
        logic load;        // commit the next value this cycle
        logic valid;       // entry lies below the count
        logic take_right;  // entry sits at or past the removed slot
        logic push;        // a new head goes in, everything moves down
        logic is_head;     // first cell of the row
        logic is_tail;     // last entry after removal
    } t_cell_ctl;

endpackage

// ===== hw/rtl/slru_cell.sv =====
`timescale 1ns / 1ps
// one entry of a segment row: holds a block number, compares it, shifts
// depends on slru_pkg
module slru_cell #(
    parameter int ID_BITS = slru_pkg::ID_BITS_DEF
) (
    input  logic                i_clk,
    input  slru_pkg::t_cell_ctl i_ctl,
    input  logic [ID_BITS-1:0]  i_lookup_id,
    input  logic [ID_BITS-1:0]  i_push_id,
    input  logic [ID_BITS-1:0]  i_right_value,
    input  logic [ID_BITS-1:0]  i_left_mid,
    output logic [ID_BITS-1:0]  o_value,
    output logic [ID_BITS-1:0]  o_mid,
    output logic [ID_BITS-1:0]  o_tail,
    output logic                o_match
);
    import slru_pkg::*;

    logic [ID_BITS-1:0] r_value;
    logic [ID_BITS-1:0] n_value;

    // value after the removal step closes the gap
    assign o_mid   = i_ctl.take_right ? i_right_value : r_value;
    assign o_tail  = i_ctl.is_tail ? o_mid : '0;
    assign o_match = i_ctl.valid && (r_value == i_lookup_id);
    assign o_value = r_value;

    always_comb begin
        if (i_ctl.push) begin
            n_value = i_ctl.is_head ? i_push_id : i_left_mid;
        end else begin
            n_value = o_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
        end
    end

endmodule

// ===== hw/rtl/slru_segment.sv =====
`timescale 1ns / 1ps
// one lru segment: a row of cells, head first, with its fill count
// depends on slru_pkg and slru_cell
module slru_segment #(
    parameter int DEPTH   = slru_pkg::SEG_DEPTH_DEF,
    parameter int ID_BITS = slru_pkg::ID_BITS_DEF,
    parameter int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW      = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [ID_BITS-1:0] i_lookup_id,
    input  logic               i_rem_en,
    input  logic               i_push,
    input  logic [ID_BITS-1:0] i_push_id,
    input  logic               i_drop,
    output logic               o_hit,
    output logic [PW-1:0]      o_hit_pos,
    output logic [CW-1:0]      o_count_rem,
    output logic [ID_BITS-1:0] o_tail
);
    import slru_pkg::*;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [ID_BITS-1:0] w_value [DEPTH];
    logic [ID_BITS-1:0] w_mid   [DEPTH];
    logic [ID_BITS-1:0] w_tail  [DEPTH];
    logic [DEPTH-1:0]   w_match;
    t_cell_ctl          w_ctl   [DEPTH];

    assign o_count_rem = r_count - CW'(i_rem_en);

    // first matching entry
    always_comb begin
        o_hit_pos = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                o_hit_pos = PW'(k);
            end
        end
    end
    assign o_hit = |w_match;

    always_comb begin
        o_tail = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_tail = o_tail | w_tail[k];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CW-1:0] POS = CW'(g);

        assign w_ctl[g].load       = i_load;
        assign w_ctl[g].valid      = POS < r_count;
        assign w_ctl[g].take_right = i_rem_en && (PW'(g) >= o_hit_pos);
        assign w_ctl[g].push       = i_push;
        assign w_ctl[g].is_head    = (g == 0);
        assign w_ctl[g].is_tail    = (o_count_rem != '0) && (POS == o_count_rem - CW'(1));

        slru_cell #(
            .ID_BITS(ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_lookup_id  (i_lookup_id),
            .i_push_id    (i_push_id),
            .i_right_value(w_value[(g < DEPTH - 1) ? g + 1 : g]),
            .i_left_mid   (w_mid[(g > 0) ? g - 1 : g]),
            .o_value      (w_value[g]),
            .o_mid        (w_mid[g]),
            .o_tail       (w_tail[g]),
            .o_match      (w_match[g])
        );
    end

    assign n_count = o_count_rem - CW'(i_drop) + CW'(i_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_load) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/segmented_lru_replacement.sv =====
`timescale 1ns / 1ps
// segmented lru replacement: probation and protected rows of cells
// an accepted input transfer has its result in the output register in the next cycle
// throughput: one access per cycle while the result register is free; both rows compare all entries at once and
//   shift by one cell in the same cycle, the output register parts the channels
// reset: synchronous active low, clears both counts and the output valid and
//   sets both capacities to 4; the stored block numbers are not cleared
// depends on slru_pkg, slru_segment, slru_cell
module segmented_lru_replacement #(
    parameter int SEGMENT_DEPTH = slru_pkg::SEG_DEPTH_DEF,
    parameter int BLOCK_ID_BITS = slru_pkg::ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [slru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slru_pkg::CAP_W-1:0]       i_cfg_data,
    // access channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [slru_pkg::ID_PORT_W-1:0]   i_block_id,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_outcome,
    output logic                             o_evict_valid,
    output logic [slru_pkg::ID_PORT_W-1:0]   o_evict_block
);
    import slru_pkg::*;

    localparam int PW     = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
    localparam int CW     = $clog2(SEGMENT_DEPTH + 1);
    localparam int CMP_W  = (CW > CAP_W) ? CW : CAP_W;
    localparam int WIDE_W = (BLOCK_ID_BITS > ID_PORT_W) ? BLOCK_ID_BITS : ID_PORT_W;

    // capacity registers
    logic [CAP_W-1:0] r_prob_cap;
    logic [CAP_W-1:0] r_prot_cap;

    // output register
    logic                 r_out_valid;
    logic [1:0]           r_outcome;
    logic                 r_evict_valid;
    logic [ID_PORT_W-1:0] r_evict_block;

    // access decode
    logic                     w_accept;
    logic [BLOCK_ID_BITS-1:0] w_id;
    logic                     w_prob_hit;
    logic [PW-1:0]            w_prob_pos;
    logic [CW-1:0]            w_prob_cnt_rem;
    logic [BLOCK_ID_BITS-1:0] w_prob_tail;
    logic                     w_prot_hit;
    logic [PW-1:0]            w_prot_pos;
    logic [CW-1:0]            w_prot_cnt_rem;
    logic [BLOCK_ID_BITS-1:0] w_prot_tail;
    logic                     w_miss;
    logic                     w_prot_rem;
    logic                     w_prot_push;
    logic                     w_demote;
    logic                     w_prob_push;
    logic [BLOCK_ID_BITS-1:0] w_prob_push_id;
    logic                     w_evict;
    logic [1:0]               w_outcome;
    logic                     w_prob_pos_unused;

    // capacity of zero acts as one, anything above the row depth as the depth
    function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            return CMP_W'(1);
        end else if (c > CMP_W'(SEGMENT_DEPTH)) begin
            return CMP_W'(SEGMENT_DEPTH);
        end
        return c;
    endfunction

    // the result register frees up when it is empty or being taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // only the low block number bits take part
    assign w_id = BLOCK_ID_BITS'(WIDE_W'(i_block_id));

    // probation hit: remove there, insert at protected head
    // protected hit below the head: remove there, reinsert at the head
    // protected head hit: no change
    assign w_miss      = !w_prob_hit && !w_prot_hit;
    assign w_prot_rem  = !w_prob_hit && w_prot_hit && (w_prot_pos != '0);
    assign w_prot_push = w_prob_hit || w_prot_rem;

    // a full protected row hands its tail down to probation
    assign w_demote = w_prot_push
                   && (CMP_W'(w_prot_cnt_rem) >= eff_cap(r_prot_cap));

    // probation takes either the missed block or the demoted tail
    assign w_prob_push    = w_miss || w_demote;
    assign w_prob_push_id = w_miss ? w_id : w_prot_tail;

    // a full probation row drops its tail out of the cache
    assign w_evict = w_prob_push
                  && (CMP_W'(w_prob_cnt_rem) >= eff_cap(r_prob_cap));

    always_comb begin
        priority if (w_prob_hit) begin
            w_outcome = OUT_PROB_HIT;
        end else if (w_prot_hit && (w_prot_pos == '0)) begin
            w_outcome = OUT_PROT_HEAD;
        end else if (w_prot_hit) begin
            w_outcome = OUT_PROT_HIT;
        end else begin
            w_outcome = OUT_MISS;
        end
    end

    slru_segment #(
        .DEPTH  (SEGMENT_DEPTH),
        .ID_BITS(BLOCK_ID_BITS),
        .PW     (PW),
        .CW     (CW)
    ) u_prob (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_lookup_id(w_id),
        .i_rem_en   (w_prob_hit),
        .i_push     (w_prob_push),
        .i_push_id  (w_prob_push_id),
        .i_drop     (w_evict),
        .o_hit      (w_prob_hit),
        .o_hit_pos  (w_prob_pos),
        .o_count_rem(w_prob_cnt_rem),
        .o_tail     (w_prob_tail)
    );

    slru_segment #(
        .DEPTH  (SEGMENT_DEPTH),
        .ID_BITS(BLOCK_ID_BITS),
        .PW     (PW),
        .CW     (CW)
    ) u_prot (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_lookup_id(w_id),
        .i_rem_en   (w_prot_rem),
        .i_push     (w_prot_push),
        .i_push_id  (w_id),
        .i_drop     (w_demote),
        .o_hit      (w_prot_hit),
        .o_hit_pos  (w_prot_pos),
        .o_count_rem(w_prot_cnt_rem),
        .o_tail     (w_prot_tail)
    );

    // probation position is only needed inside its row
    assign w_prob_pos_unused = ^w_prob_pos;

    // capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob_cap <= CAP_RESET;
            r_prot_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROB_CAP: r_prob_cap <= i_cfg_data;
                CFG_PROT_CAP: r_prot_cap <= i_cfg_data;
                default:      r_prob_cap <= r_prob_cap;
            endcase
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, evicted block reads zero when nothing is evicted
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_outcome     <= w_outcome;
            r_evict_valid <= w_evict;
            r_evict_block <= w_evict ? ID_PORT_W'(WIDE_W'(w_prob_tail)) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_evict_valid = r_evict_valid;
    assign o_evict_block = r_evict_block;

endmodule
